>>> src/xeu_pkg.sv
// Shared types, constants and helper functions of the XML entity unescape stream.
`timescale 1ns / 1ps

package xeu_pkg;

    localparam int REF_WINDOW_DEF = 12;
    localparam int CMDQ_DEPTH     = 4;

    localparam logic [20:0] CP_LIMIT = 21'h10FFFF;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;

    // entity names, left aligned, one byte per character
    localparam logic [31:0] NAME_AMP  = 32'h616D7000;
    localparam logic [31:0] NAME_LT   = 32'h6C740000;
    localparam logic [31:0] NAME_GT   = 32'h67740000;
    localparam logic [31:0] NAME_QUOT = 32'h71756F74;
    localparam logic [31:0] NAME_APOS = 32'h61706F73;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef enum logic {
        CMD_BYTE,
        CMD_CP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [20:0] val;
        logic        seg_end;
    } cmd_t;

    typedef struct packed {
        logic        m_amp;
        logic        m_lt;
        logic        m_gt;
        logic        m_quot;
        logic        m_apos;
        logic        num_ok;
        logic        hex;
        logic        has_dig;
        logic        ovf;
        logic [20:0] acc;
    } cls_t;

    // bit 4: valid digit, bits 3:0: digit value
    function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
        logic [7:0] t;
        logic [4:0] r;
        t = 8'h00;
        r = 5'h00;
        if (b inside {[8'h30:8'h39]})
        begin
            t = b - 8'h30;
            r = {1'b1, t[3:0]};
        end
        else if (hex && (b inside {[8'h61:8'h66]}))
        begin
            t = b - 8'h57;
            r = {1'b1, t[3:0]};
        end
        else if (hex && (b inside {[8'h41:8'h46]}))
        begin
            t = b - 8'h37;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

    // index of the final byte of a command's output
    function automatic logic [1:0] utf8_last(input cmd_t c);
        logic [1:0] r;
        if (c.kind == CMD_BYTE || c.val < 21'h80)
            r = 2'd0;
        else if (c.val < 21'h800)
            r = 2'd1;
        else if (c.val < 21'h10000)
            r = 2'd2;
        else
            r = 2'd3;
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input cmd_t c, input logic [1:0] idx);
        logic [1:0]  n;
        logic [20:0] v;
        logic [7:0]  r;
        n = utf8_last(c);
        v = c.val;
        r = v[7:0];
        case (n)
            2'd0: r = v[7:0];
            2'd1:
            begin
                if (idx == 2'd0)
                    r = {3'b110, v[10:6]};
                else
                    r = {2'b10, v[5:0]};
            end
            2'd2:
            begin
                if (idx == 2'd0)
                    r = {4'b1110, v[15:12]};
                else if (idx == 2'd1)
                    r = {2'b10, v[11:6]};
                else
                    r = {2'b10, v[5:0]};
            end
            default:
            begin
                if (idx == 2'd0)
                    r = {5'b11110, v[20:18]};
                else if (idx == 2'd1)
                    r = {2'b10, v[17:12]};
                else if (idx == 2'd2)
                    r = {2'b10, v[11:6]};
                else
                    r = {2'b10, v[5:0]};
            end
        endcase
        return r;
    endfunction

endpackage

>>> src/xeu_front.sv
// Front end: byte buffer, reference scanner and classifier issuing output commands.
`timescale 1ns / 1ps

module xeu_front #(
    parameter int REF_WINDOW = xeu_pkg::REF_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              raw_valid,
    output logic              raw_stall,
    input  xeu_pkg::in_item_t raw,
    output logic              q_push,
    output xeu_pkg::cmd_t     q_cmd,
    input  logic              q_full
);
    import xeu_pkg::*;

    localparam int DEPTH    = REF_WINDOW;
    localparam int HOLD_MAX = REF_WINDOW - 1;
    localparam int HW       = $clog2(REF_WINDOW);
    localparam int CW       = $clog2(REF_WINDOW + 1);

    function automatic logic name_char(input logic [31:0] word, input int n, input int pos,
                                       input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (pos < n)
            hit = (b == word[31 - 8 * pos -: 8]);
        return hit;
    endfunction

    logic [7:0]    buf_reg [DEPTH];
    logic [7:0]    buf_next [DEPTH];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [HW-1:0] h_reg, h_next;
    logic          pend_reg, pend_next;
    logic          last_reg, last_next;
    cls_t          cls_reg, cls_next;

    logic [CW-1:0] h_ext;
    logic [CW-1:0] h_inc;
    logic [CW-1:0] sh;
    logic [CW-1:0] cnt_after;
    logic [7:0]    cur;
    logic          have_byte;
    logic          at_end;
    logic          is_semi;
    logic          full_hold;
    logic          nm_amp, nm_lt, nm_gt, nm_quot, nm_apos;
    logic          num_good;
    logic          res_ok;
    logic          fail_now;
    logic          go;
    logic          idle;
    logic          take_ok;
    logic          take;
    cmd_t          res_cmd;
    cls_t          cls_upd;
    cls_t          cls_init;

    assign h_ext     = CW'(h_reg);
    assign h_inc     = h_ext + CW'(1);
    assign have_byte = h_ext < cnt_reg;
    assign cur       = buf_reg[h_reg];
    assign at_end    = last_reg && (h_inc == cnt_reg);
    assign is_semi   = (cur == CH_SEMI);
    assign full_hold = (int'(h_reg) >= HOLD_MAX);

    assign nm_amp   = cls_reg.m_amp  && (int'(h_reg) == 3);
    assign nm_lt    = cls_reg.m_lt   && (int'(h_reg) == 2);
    assign nm_gt    = cls_reg.m_gt   && (int'(h_reg) == 2);
    assign nm_quot  = cls_reg.m_quot && (int'(h_reg) == 4);
    assign nm_apos  = cls_reg.m_apos && (int'(h_reg) == 4);
    assign num_good = cls_reg.num_ok && cls_reg.has_dig && !cls_reg.ovf;
    assign res_ok   = nm_amp || nm_lt || nm_gt || nm_quot || nm_apos || num_good;

    assign fail_now = pend_reg && (is_semi ? !res_ok : (full_hold || at_end));
    assign go       = have_byte && !q_full;
    assign idle     = (h_ext == cnt_reg);
    assign take_ok  = idle || (go && (h_inc == cnt_reg) && !fail_now);
    assign raw_stall = !take_ok;
    assign take     = raw_valid && take_ok;

    always_comb
    begin
        res_cmd.kind    = CMD_BYTE;
        res_cmd.seg_end = at_end;
        res_cmd.val     = 21'(cur);
        if (nm_amp)
            res_cmd.val = 21'(CH_AMP);
        else if (nm_lt)
            res_cmd.val = 21'(CH_LT);
        else if (nm_gt)
            res_cmd.val = 21'(CH_GT);
        else if (nm_quot)
            res_cmd.val = 21'(CH_QUOT);
        else if (nm_apos)
            res_cmd.val = 21'(CH_APOS);
        else
        begin
            res_cmd.kind = CMD_CP;
            res_cmd.val  = cls_reg.acc;
        end
    end

    always_comb
    begin
        cls_init         = '0;
        cls_init.m_amp   = 1'b1;
        cls_init.m_lt    = 1'b1;
        cls_init.m_gt    = 1'b1;
        cls_init.m_quot  = 1'b1;
        cls_init.m_apos  = 1'b1;
    end

    // classifier update for one more held byte
    always_comb
    begin
        logic [4:0]  dg;
        logic [24:0] prod;
        logic [24:0] sum;
        int          pos;
        pos  = int'(h_reg);
        dg   = digit_of(cur, cls_reg.hex);
        prod = '0;
        sum  = '0;
        cls_upd        = cls_reg;
        cls_upd.m_amp  = cls_reg.m_amp  && name_char(NAME_AMP, 3, pos, cur);
        cls_upd.m_lt   = cls_reg.m_lt   && name_char(NAME_LT, 2, pos, cur);
        cls_upd.m_gt   = cls_reg.m_gt   && name_char(NAME_GT, 2, pos, cur);
        cls_upd.m_quot = cls_reg.m_quot && name_char(NAME_QUOT, 4, pos, cur);
        cls_upd.m_apos = cls_reg.m_apos && name_char(NAME_APOS, 4, pos, cur);
        if (pos == 0)
            cls_upd.num_ok = (cur == CH_HASH);
        else if (pos == 1 && (cur == CH_LX || cur == CH_UX))
            cls_upd.hex = 1'b1;
        else if (!dg[4])
            cls_upd.num_ok = 1'b0;
        else
        begin
            cls_upd.has_dig = 1'b1;
            if (cls_reg.hex)
                prod = {cls_reg.acc, 4'b0000};
            else
                prod = 25'({cls_reg.acc, 3'b000}) + 25'({cls_reg.acc, 1'b0});
            sum = prod + 25'(dg[3:0]);
            if (!cls_reg.ovf)
            begin
                if (sum > 25'(CP_LIMIT))
                    cls_upd.ovf = 1'b1;
                else
                    cls_upd.acc = sum[20:0];
            end
        end
    end

    always_comb
    begin
        q_push        = 1'b0;
        q_cmd.kind    = CMD_BYTE;
        q_cmd.val     = 21'(cur);
        q_cmd.seg_end = at_end;
        pend_next     = pend_reg;
        h_next        = h_reg;
        cls_next      = cls_reg;
        sh            = '0;
        if (go)
        begin
            if (!pend_reg)
            begin
                sh = CW'(1);
                if (cur == CH_AMP && !at_end)
                begin
                    pend_next = 1'b1;
                    h_next    = '0;
                    cls_next  = cls_init;
                end
                else
                    q_push = 1'b1;
            end
            else if (is_semi && res_ok)
            begin
                q_push    = 1'b1;
                q_cmd     = res_cmd;
                pend_next = 1'b0;
                h_next    = '0;
                sh        = h_inc;
            end
            else if (fail_now)
            begin
                // emit the '&' and rescan from the first held byte
                q_push        = 1'b1;
                q_cmd.val     = 21'(CH_AMP);
                q_cmd.seg_end = 1'b0;
                pend_next     = 1'b0;
                h_next        = '0;
            end
            else
            begin
                h_next   = h_reg + HW'(1);
                cls_next = cls_upd;
            end
        end
    end

    always_comb
    begin
        logic [CW:0] src;
        src       = '0;
        cnt_after = cnt_reg - sh;
        for (int i = 0; i < DEPTH; i++)
        begin
            src = (CW+1)'(i) + (CW+1)'(sh);
            if (src < (CW+1)'(DEPTH))
                buf_next[i] = buf_reg[src[HW-1:0]];
            else
                buf_next[i] = buf_reg[i];
        end
        if (take)
            buf_next[cnt_after[HW-1:0]] = raw.in_byte;
        cnt_next  = cnt_after + CW'(take);
        last_next = take ? raw.in_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            h_reg    <= '0;
            pend_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            h_reg    <= h_next;
            pend_reg <= pend_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        cls_reg <= cls_next;
    end

endmodule

>>> src/xeu_cmd_fifo.sv
// Short command queue between the scanner and the output expander.
`timescale 1ns / 1ps

module xeu_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xeu_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output xeu_pkg::cmd_t dout,
    output logic          empty
);
    import xeu_pkg::*;

    localparam int AW = $clog2(CMDQ_DEPTH);
    localparam int NW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          mem_reg [CMDQ_DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [NW-1:0] n_reg, n_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (n_reg == NW'(CMDQ_DEPTH));
    assign empty   = (n_reg == '0);
    assign dout    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (do_push)
            wr_next = (wr_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        if (do_pop)
            rd_next = (rd_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        n_next = n_reg + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            n_reg  <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            n_reg  <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= din;
    end

endmodule

>>> src/xeu_back.sv
// Back end: expands commands into output bytes (UTF-8 for code points) with an output register.
`timescale 1ns / 1ps

module xeu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  xeu_pkg::cmd_t      q_cmd,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               dec_valid,
    input  logic               dec_stall,
    output xeu_pkg::out_item_t dec
);
    import xeu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    out_item_t  out_reg, out_next;
    logic       load;
    logic       at_tail;

    assign load      = !vld_reg || !dec_stall;
    assign at_tail   = (idx_reg == utf8_last(q_cmd));
    assign dec_valid = vld_reg;
    assign dec       = out_reg;

    always_comb
    begin
        q_pop             = 1'b0;
        idx_next          = idx_reg;
        vld_next          = vld_reg;
        out_next.out_byte = utf8_byte(q_cmd, idx_reg);
        out_next.out_last = q_cmd.seg_end && at_tail;
        if (load)
        begin
            vld_next = !q_empty;
            if (!q_empty)
            begin
                if (at_tail)
                begin
                    q_pop    = 1'b1;
                    idx_next = 2'd0;
                end
                else
                    idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_empty)
            out_reg <= out_next;
    end

endmodule

>>> src/xml_entity_unescape_stream.sv
// Top level of the XML entity unescape stream: scanner, command queue and output expander.
//
// Decodes &amp; &lt; &gt; &quot; &apos; and decimal or hex numeric references (up to 0x10FFFF,
// written out as 1 to 4 UTF-8 bytes) in a byte stream whose segments end on a byte with
// in_last set. Plain text moves at one byte per cycle while the queue has room, and a decoded
// byte passes through the byte buffer, the command queue and the output register. Input is
// stalled only while the command queue is full or while held bytes are rescanned: the scanner
// looks at one buffered byte per cycle, so after a failed reference the held bytes are
// rescanned before new input is taken. A numeric reference gives up to four output bytes at
// one per cycle from the output register while dec_stall is low, behind a four-entry command
// queue. REF_WINDOW sets the longest reference: '&' plus up to REF_WINDOW-1 bytes, then ';'.
`timescale 1ns / 1ps

module xml_entity_unescape_stream #(
    parameter int REF_WINDOW = xeu_pkg::REF_WINDOW_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               raw_valid,
    output logic               raw_stall,
    input  xeu_pkg::in_item_t  raw,
    output logic               dec_valid,
    input  logic               dec_stall,
    output xeu_pkg::out_item_t dec
);
    import xeu_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_din;
    cmd_t q_dout;

    xeu_front #(
        .REF_WINDOW (REF_WINDOW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw       (raw),
        .q_push    (q_push),
        .q_cmd     (q_din),
        .q_full    (q_full)
    );

    xeu_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    xeu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (q_dout),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec       (dec)
    );

endmodule
